// ===== rtl/fbfr_pkg.sv =====
package fbfr_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned HdrWords = 4;

  // configuration register indexes
  localparam logic [1:0] CfgSyncFirst  = 2'd0;
  localparam logic [1:0] CfgSyncSecond = 2'd1;
  localparam logic [1:0] CfgMarker     = 2'd2;

  localparam logic [WordW-1:0] SyncFirstRst  = 16'h6789;
  localparam logic [WordW-1:0] SyncSecondRst = 16'hABCD;
  localparam logic [ByteW-1:0] MarkerRst     = 8'hEF;

  // header word positions
  localparam logic [1:0] HdrSync0  = 2'd0;
  localparam logic [1:0] HdrSync1  = 2'd1;
  localparam logic [1:0] HdrMarker = 2'd2;
  localparam logic [1:0] HdrSum    = 2'd3;

  localparam logic [ByteW-1:0] SumBias = 8'd3;

  typedef enum logic [1:0] {
    STAT_WORD   = 2'd0,
    STAT_OK     = 2'd1,
    STAT_CSUM   = 2'd2,
    STAT_HEADER = 2'd3
  } status_e;

  typedef struct packed {
    logic             seed;
    logic [ByteW-1:0] seed_val;
    logic             step;
    logic [ByteW-1:0] step_byte;
  } sum_cmd_t;

endpackage

// ===== rtl/fbfr_sum_unit.sv =====
module fbfr_sum_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbfr_pkg::sum_cmd_t            cmd_i,
  output logic [fbfr_pkg::WordW-1:0]    sum_o,
  output logic [fbfr_pkg::WordW-1:0]    sum_next_o
);

  logic [fbfr_pkg::WordW-1:0] sum_q, sum_d;
  logic [fbfr_pkg::WordW-1:0] add_t;
  logic [fbfr_pkg::WordW-1:0] mul_t;

  // one checksum byte: (sum + byte + 3) * 19, modulo 2^16
  always_comb begin
    add_t = sum_q + fbfr_pkg::WordW'(cmd_i.step_byte)
          + fbfr_pkg::WordW'(fbfr_pkg::SumBias);
    mul_t = (add_t << 4) + (add_t << 1) + add_t;
    sum_d = sum_q;
    if (cmd_i.seed) begin
      sum_d = fbfr_pkg::WordW'(cmd_i.seed_val);
    end else if (cmd_i.step) begin
      sum_d = mul_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o      = sum_q;
  assign sum_next_o = sum_d;

endmodule

// ===== rtl/fsk_block_frame_receiver_unit.sv =====
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: expected_block[7:0], rx_word[23:8]
// m_axis    out  tvalid/tready          tdata: data_word; tuser: frame_status; tlast
// cfg       in   cfg_valid/cfg_ready    cfg_index (0..2), cfg_data (low bits kept)
//
// Header words are checked in the accept cycle; a rejected header loads its result in the accept
// cycle, or waits in the hold state while the output register is full.
// Payload words: the shared checksum unit folds in the high byte in the accept cycle and
// the low byte in the next, posting the result then, or from the hold state while the output register is full.
// A result waiting at m_axis does not stop the next request being taken; the
// sequencer only holds when it has a new result and the output register is full.
// Reset clears position, checksum and output valid; registers return to defaults.
module fsk_block_frame_receiver_unit #(
  parameter int unsigned DATA_WORDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] expected_block, [23:8] rx_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] data_word
  output logic [1:0]  m_axis_tuser,   // [1:0] frame_status
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned PosW = $clog2(DATA_WORDS + fbfr_pkg::HdrWords);
  localparam logic [PosW-1:0] LastPos = PosW'(DATA_WORDS + fbfr_pkg::HdrWords - 1);
  localparam logic [PosW-1:0] HdrEnd  = PosW'(fbfr_pkg::HdrWords);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LO   = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [15:0]     sync_first_q, sync_second_q;
  logic [7:0]      marker_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic            reject_q, reject_d;
  logic [15:0]     sent_q, sent_d;
  logic [15:0]     word_q, word_d;

  logic            out_valid_q;
  logic [15:0]     out_word_q;
  logic [1:0]      out_stat_q;
  logic            out_end_q;

  logic            load;
  logic [15:0]     ld_word;
  fbfr_pkg::status_e ld_stat;
  logic            ld_end;

  fbfr_pkg::sum_cmd_t    cmd;
  logic [15:0]     sum_q, sum_next, fin_sum;
  logic            can_load, accept, is_last;
  logic [7:0]      in_blk;
  logic [15:0]     in_word;

  assign in_blk   = s_axis_tdata[7:0];
  assign in_word  = s_axis_tdata[23:8];
  assign can_load = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_last  = (pos_q == LastPos);
  assign cfg_ready = 1'b1;

  fbfr_sum_unit u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sum_o      (sum_q),
    .sum_next_o (sum_next)
  );

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    hdr_ok_d = hdr_ok_q;
    reject_d = reject_q;
    sent_d   = sent_q;
    word_d   = word_q;
    cmd      = '0;
    load     = 1'b0;
    ld_word  = word_q;
    ld_stat  = fbfr_pkg::STAT_WORD;
    ld_end   = 1'b0;
    fin_sum  = sum_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (pos_q < HdrEnd) begin
            pos_d = pos_q + PosW'(1);
            case (pos_q[1:0])
              fbfr_pkg::HdrSync0: begin
                if (in_word != sync_first_q) hdr_ok_d = 1'b0;
              end
              fbfr_pkg::HdrSync1: begin
                if (in_word != sync_second_q) hdr_ok_d = 1'b0;
              end
              fbfr_pkg::HdrMarker: begin
                if (in_word[15:8] != marker_q || in_word[7:0] != in_blk) hdr_ok_d = 1'b0;
                cmd.seed     = 1'b1;
                cmd.seed_val = in_blk;
              end
              fbfr_pkg::HdrSum: begin
                sent_d = in_word;
                if (!hdr_ok_q) begin
                  // reject the header and hunt again
                  pos_d    = '0;
                  hdr_ok_d = 1'b1;
                  ld_word  = '0;
                  ld_stat  = fbfr_pkg::STAT_HEADER;
                  ld_end   = 1'b1;
                  if (can_load) begin
                    load = 1'b1;
                  end else begin
                    reject_d = 1'b1;
                    state_d  = ST_OUT;
                  end
                end
              end
              default: ;
            endcase
          end else begin
            // high byte goes through the unit now, low byte next cycle
            cmd.step      = 1'b1;
            cmd.step_byte = in_word[15:8];
            word_d        = in_word;
            state_d       = ST_LO;
          end
        end
      end
      ST_LO: begin
        cmd.step      = 1'b1;
        cmd.step_byte = word_q[7:0];
        fin_sum       = sum_next;
        if (can_load) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (reject_q) begin
          ld_word = '0;
          ld_stat = fbfr_pkg::STAT_HEADER;
          ld_end  = 1'b1;
        end
        if (can_load) begin
          load     = 1'b1;
          reject_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // payload result, posted from the low-byte cycle or from the hold state
    if ((state_q == ST_LO) || ((state_q == ST_OUT) && !reject_q)) begin
      if (is_last) begin
        ld_stat = (fin_sum == sent_q) ? fbfr_pkg::STAT_OK : fbfr_pkg::STAT_CSUM;
        ld_end  = 1'b1;
        if (load) begin
          pos_d    = '0;
          hdr_ok_d = 1'b1;
        end
      end else if (load) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      hdr_ok_q      <= 1'b1;
      reject_q      <= 1'b0;
      sent_q        <= '0;
      out_valid_q   <= 1'b0;
      sync_first_q  <= fbfr_pkg::SyncFirstRst;
      sync_second_q <= fbfr_pkg::SyncSecondRst;
      marker_q      <= fbfr_pkg::MarkerRst;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      hdr_ok_q <= hdr_ok_d;
      reject_q <= reject_d;
      sent_q   <= sent_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fbfr_pkg::CfgSyncFirst:  sync_first_q  <= cfg_data;
          fbfr_pkg::CfgSyncSecond: sync_second_q <= cfg_data;
          fbfr_pkg::CfgMarker:     marker_q      <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (load) begin
      out_word_q <= ld_word;
      out_stat_q <= ld_stat;
      out_end_q  <= ld_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tlast  = out_end_q;

endmodule

// ===== tb/fbfr_checker.sv =====
module fbfr_checker #(
  parameter int unsigned DATA_WORDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [23:0] s_data_i,    // [7:0] expected_block, [23:8] rx_word
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,    // [15:0] data_word
  input  logic [1:0]  m_user_i,    // [1:0] frame_status
  input  logic        m_last_i,    // frame_end
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned err_cnt_o,
  output int unsigned pend_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fbfr_pkg::*;

  localparam logic [WordW-1:0] SumMul = 16'd19;

  typedef struct packed {
    logic [WordW-1:0] data;
    status_e          status;
    logic             last;
  } frame_res_t;

  frame_res_t frame_res_q[$];

  logic [WordW-1:0] sync_a;
  logic [WordW-1:0] sync_b;
  logic [ByteW-1:0] marker;
  int unsigned      word_pos;
  logic             hdr_good;
  logic [WordW-1:0] run_sum;
  logic [WordW-1:0] sent_sum;

  initial begin
    err_cnt_o  = 0;
    pend_cnt_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: frame receiver mismatch: %s", $time, msg);
    err_cnt_o++;
  endtask

  function automatic logic [WordW-1:0] fold_byte(input logic [WordW-1:0] acc,
                                                  input logic [ByteW-1:0] b);
    logic [WordW-1:0] t;
    t = acc + WordW'(b) + WordW'(SumBias);
    return t * SumMul;
  endfunction

  task automatic take_word(input logic [ByteW-1:0] blk, input logic [WordW-1:0] w);
    frame_res_t r;
    if (word_pos < HdrWords) begin
      case (word_pos[1:0])
        HdrSync0: begin
          if (w != sync_a) hdr_good = 1'b0;
          word_pos++;
        end
        HdrSync1: begin
          if (w != sync_b) hdr_good = 1'b0;
          word_pos++;
        end
        HdrMarker: begin
          if (w[15:8] != marker || w[7:0] != blk) hdr_good = 1'b0;
          run_sum = {8'd0, blk};
          word_pos++;
        end
        default: begin
          sent_sum = w;
          if (!hdr_good) begin
            r = '{data: '0, status: STAT_HEADER, last: 1'b1};
            frame_res_q.push_back(r);
            word_pos = 0;
            hdr_good = 1'b1;
          end else begin
            word_pos++;
          end
        end
      endcase
    end else begin
      run_sum = fold_byte(fold_byte(run_sum, w[15:8]), w[7:0]);
      r.data = w;
      if (word_pos - HdrWords + 1 >= DATA_WORDS) begin
        r.status = (run_sum == sent_sum) ? STAT_OK : STAT_CSUM;
        r.last   = 1'b1;
        word_pos = 0;
        hdr_good = 1'b1;
      end else begin
        r.status = STAT_WORD;
        r.last   = 1'b0;
        word_pos++;
      end
      frame_res_q.push_back(r);
    end
  endtask

  task automatic check_result();
    frame_res_t e;
    if (frame_res_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: word %h status %0d last %0b",
                                m_data_i, m_user_i, m_last_i));
    end else begin
      e = frame_res_q.pop_front();
      if (m_data_i != e.data)
        report_mismatch($sformatf("data_word %h, want %h", m_data_i, e.data));
      if (m_user_i != e.status)
        report_mismatch($sformatf("frame_status %0d, want %0d", m_user_i, e.status));
      if (m_last_i != e.last)
        report_mismatch($sformatf("frame_end %0b, want %0b", m_last_i, e.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_a   = SyncFirstRst;
      sync_b   = SyncSecondRst;
      marker   = MarkerRst;
      word_pos = 0;
      hdr_good = 1'b1;
      run_sum  = '0;
      sent_sum = '0;
      frame_res_q.delete();
    end else begin
      // check the outgoing result first: a request taken at this edge cannot answer here
      if (m_valid_i && m_ready_i) check_result();
      if (s_valid_i && s_ready_i) take_word(s_data_i[7:0], s_data_i[23:8]);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSyncFirst:  sync_a = cfg_data_i;
          CfgSyncSecond: sync_b = cfg_data_i;
          CfgMarker:     marker = cfg_data_i[ByteW-1:0];
          default: ;
        endcase
      end
    end
    pend_cnt_o = frame_res_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fbfr_pkg::*;

  localparam int unsigned      DataWords  = 16;
  localparam int unsigned      PhaseItems = 72;
  localparam logic [1:0]       CfgNone    = 2'd3;
  localparam logic [WordW-1:0] SumMul     = 16'd19;

  typedef enum int unsigned {
    FRM_GOOD,
    FRM_BAD_SUM,
    FRM_BAD_HDR,
    FRM_NOISE
  } frame_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] expected_block, [23:8] rx_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] data_word
  logic [1:0]  m_axis_tuser;         // [1:0] frame_status
  logic        m_axis_tlast;         // frame_end
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = CfgSyncFirst;
  logic [15:0] cfg_data      = '0;

  int unsigned err_cnt;
  int unsigned pend_cnt;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned n_sent        = 0;

  logic [WordW-1:0] sync_a   = SyncFirstRst;
  logic [WordW-1:0] sync_b   = SyncSecondRst;
  logic [ByteW-1:0] marker_v = MarkerRst;
  logic [WordW-1:0] pay_buf [DataWords];

  fsk_block_frame_receiver_unit #(
    .DATA_WORDS(DataWords)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  fbfr_checker #(
    .DATA_WORDS(DataWords)
  ) u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .m_user_i   (m_axis_tuser),
    .m_last_i   (m_axis_tlast),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // sender's checksum over pay_buf, seeded with the block number
  function automatic logic [WordW-1:0] block_sum(input logic [ByteW-1:0] blk);
    logic [WordW-1:0] acc;
    acc = {8'd0, blk};
    for (int i = 0; i < DataWords; i++) begin
      acc = 16'((acc + pay_buf[i][15:8] + SumBias) * SumMul);
      acc = 16'((acc + pay_buf[i][7:0] + SumBias) * SumMul);
    end
    return acc;
  endfunction

  task automatic send_item(input logic [ByteW-1:0] blk, input logic [WordW-1:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, blk};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic send_frame(input frame_kind_e kind, input logic [ByteW-1:0] blk);
    logic [WordW-1:0] hdr [HdrWords];
    logic [ByteW-1:0] blk_in;
    int unsigned      spot;
    hdr[0] = sync_a;
    hdr[1] = sync_b;
    hdr[2] = {marker_v, blk};
    hdr[3] = block_sum(blk);
    blk_in = blk;
    spot   = $urandom_range(0, HdrWords - 1);
    if (kind == FRM_NOISE) begin
      for (int i = 0; i < HdrWords; i++) hdr[i] = 16'($urandom);
    end else if (kind == FRM_BAD_SUM) begin
      hdr[3] ^= 16'($urandom_range(1, 65535));
    end else if (kind == FRM_BAD_HDR) begin
      // the sum word is never judged, so spend that slot on a wrong block number
      if (spot == HdrSum) blk_in ^= 8'($urandom_range(1, 255));
      else hdr[spot] ^= 16'($urandom_range(1, 65535));
    end
    for (int i = 0; i < HdrWords; i++) begin
      send_item((i == HdrMarker) ? blk_in : 8'($urandom), hdr[i]);
    end
    if (kind == FRM_GOOD || kind == FRM_BAD_SUM) begin
      for (int i = 0; i < DataWords; i++) send_item(8'($urandom), pay_buf[i]);
    end
  endtask

  // drop valid, then hold until every result is back and the pipe has emptied
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    // let the checker count the last request before polling
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [15:0] a, input logic [15:0] b,
                          input logic [15:0] m);
    cfg_put(CfgSyncFirst, a);
    cfg_put(CfgSyncSecond, b);
    cfg_put(CfgMarker, m);
    cfg_put(CfgNone, 16'($urandom));
    cfg_valid <= 1'b0;
    sync_a   = a;
    sync_b   = b;
    marker_v = m[ByteW-1:0];
  endtask

  initial begin
    frame_kind_e kind;
    int unsigned pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) settle();
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          // header rejected: no header word matches, field extremes throughout
          send_item(8'h00, 16'h0000);
          send_item(8'hFF, 16'hFFFF);
          send_item(8'h00, 16'hFFFF);
          send_item(8'hFF, 16'h0000);
          for (int i = 0; i < DataWords; i++) begin
            pay_buf[i] = (i < 4) ? ((i % 2 == 0) ? 16'h0000 : 16'hFFFF) : 16'($urandom);
          end
          send_frame(FRM_GOOD, 8'hFF);
        end
        1: begin
          set_regs(16'h0000, 16'h0000, 16'h0000);
          send_idle_pct = 76;
          stall_pct     = 0;
        end
        2: begin
          // marker register keeps only its low byte
          set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
          send_idle_pct = 0;
          stall_pct     = 76;
        end
        3: begin
          set_regs(16'($urandom), 16'($urandom), 16'($urandom));
          send_idle_pct = 30;
          stall_pct     = 30;
        end
        default: begin
          set_regs(16'($urandom), 16'($urandom), 16'($urandom));
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase

      n_sent = 0;
      while (n_sent < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) kind = FRM_GOOD;
        else if (pick < 75) kind = FRM_BAD_SUM;
        else if (pick < 90) kind = FRM_BAD_HDR;
        else kind = FRM_NOISE;
        for (int i = 0; i < DataWords; i++) pay_buf[i] = 16'($urandom);
        send_frame(kind, 8'($urandom));
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("[fsk_block_frame_receiver_unit] OK");
    end else begin
      $display("[fsk_block_frame_receiver_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[fsk_block_frame_receiver_unit] ERROR");
    $finish;
  end

endmodule
